### rtl/rrc_pkg.sv
// Shared types, constants and helper functions of the radix and Roman converter.
// No dependencies; every other file of the block uses this package.
package rrc_pkg;

  localparam int SYM_W     = 8;
  localparam int RADIX_W   = 6;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ROMAN_D_W = 4;
  localparam int PLACE_W   = 2;
  localparam int SUB_W     = 3;

  localparam int VALUE_WIDTH_DEF = 50;
  localparam int MAX_DIGITS_DEF  = 50;

  localparam logic [63:0] DEC_LIMIT = 64'd1000000000000000;
  localparam logic [63:0] ROMAN_MAX = 64'd3000;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] ROMAN_RADIX = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [SYM_W-1:0] CHAR_0   = 8'h30;
  localparam logic [SYM_W-1:0] CHAR_9   = 8'h39;
  localparam logic [SYM_W-1:0] CHAR_A   = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_Z   = 8'h5A;
  localparam logic [SYM_W-1:0] CHAR_NUL = 8'h00;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ROMAN    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_SYMBOL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROMAN_MODE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_RD,
    S_OUT,
    S_ROMAN,
    S_ERR
  } state_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // bit RADIX_W set marks a symbol that is no digit at all
  function automatic logic [RADIX_W:0] decode_symbol(input logic [SYM_W-1:0] sym);
    logic [RADIX_W:0] res;
    res = {1'b1, {RADIX_W{1'b0}}};
    if (sym >= CHAR_0 && sym <= CHAR_9) begin
      res = (RADIX_W + 1)'(sym - CHAR_0);
    end else if (sym >= CHAR_A && sym <= CHAR_Z) begin
      res = (RADIX_W + 1)'(sym - CHAR_A) + (RADIX_W + 1)'(DIGIT_TEN);
    end
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [SYM_W-1:0] res;
    if (d < DIGIT_TEN) res = CHAR_0 + SYM_W'(d);
    else res = CHAR_A + SYM_W'(d - DIGIT_TEN);
    return res;
  endfunction

  function automatic logic [SUB_W-1:0] roman_len(input logic [ROMAN_D_W-1:0] d);
    logic [SUB_W-1:0] res;
    unique case (d)
      4'd0:    res = 3'd0;
      4'd1:    res = 3'd1;
      4'd2:    res = 3'd2;
      4'd3:    res = 3'd3;
      4'd4:    res = 3'd2;
      4'd5:    res = 3'd1;
      4'd6:    res = 3'd2;
      4'd7:    res = 3'd3;
      4'd8:    res = 3'd4;
      4'd9:    res = 3'd2;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] roman_char(input logic [PLACE_W-1:0] place,
                                                  input logic [ROMAN_D_W-1:0] d,
                                                  input logic [SUB_W-1:0] sub);
    logic [SYM_W-1:0] one;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    logic [SYM_W-1:0] res;
    unique case (place)
      2'd0:    begin one = "I"; five = "V"; ten = "X"; end
      2'd1:    begin one = "X"; five = "L"; ten = "C"; end
      2'd2:    begin one = "C"; five = "D"; ten = "M"; end
      default: begin one = "M"; five = "M"; ten = "M"; end
    endcase
    if (d == 4'd9) res = (sub == '0) ? one : ten;
    else if (d == 4'd4) res = (sub == '0) ? one : five;
    else if (d >= 4'd5) res = (sub == '0) ? five : one;
    else res = one;
    return res;
  endfunction

endpackage

### rtl/rrc_in_if.sv
// Input channel of the converter: one digit symbol per word.
// Depends on rrc_pkg for the field widths.
interface rrc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rrc_pkg::SYM_W-1:0] symbol;
  logic                      last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

### rtl/rrc_out_if.sv
// Result channel of the converter: one character or one error report per word.
// Depends on rrc_pkg for the field widths.
interface rrc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rrc_pkg::SYM_W-1:0] out_char;
  logic                      last_char;
  logic [rrc_pkg::ERR_W-1:0] error_code;

  modport source (output valid, output out_char, output last_char, output error_code,
                  input ready);
  modport sink   (input valid, input out_char, input last_char, input error_code,
                  output ready);
endinterface

### rtl/rrc_div.sv
// Shared restoring divider: one quotient bit per cycle, divisor up to six bits.
// Depends on rrc_pkg.
module rrc_div #(
  parameter int VALUE_WIDTH = rrc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_WIDTH-1:0]      dividend,
  input  logic [rrc_pkg::RADIX_W-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [rrc_pkg::RADIX_W-1:0] remainder
);
  import rrc_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [RADIX_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     dvs_r;

  logic [RADIX_W:0]       shifted;
  logic                   fits;
  logic [RADIX_W:0]       rem_step;

  assign shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign fits     = shifted >= {1'b0, dvs_r};
  assign rem_step = fits ? (shifted - {1'b0, dvs_r}) : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) busy_r <= 1'b0;
        else cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_WIDTH-2:0], fits};
      rem_r <= rem_step[RADIX_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/rrc_dstore.sv
// Digit store: one write port, one registered read port.
// Depends on rrc_pkg for the digit width.
module rrc_dstore #(
  parameter int DEPTH = rrc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [rrc_pkg::RADIX_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [rrc_pkg::RADIX_W-1:0] rdata
);
  import rrc_pkg::*;

  logic [RADIX_W-1:0] mem [DEPTH];
  logic [RADIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/radix_and_roman_converter.sv
// Top level of the radix and Roman numeral converter: sequencer, accumulator,
// configuration registers and result register. Uses rrc_pkg, rrc_in_if,
// rrc_out_if, rrc_div and rrc_dstore.
//
// Usage:
//   in_if carries one ASCII digit symbol per word, most significant first;
//   last_symbol closes the number. out_if returns the converted number as a
//   run of ASCII words, most significant first, last_char on the final one,
//   or a single word with out_char 0 and a nonzero error_code.
//   cfg_we/cfg_index/cfg_data write source_base, target_base and roman_mode;
//   write them only while the block is idle.
// Timing:
//   A symbol is multiplied in the accept cycle, then added and limit checked
//   in the next. After the last symbol each output digit comes from the
//   shared bit-serial divider (Roman mode divides by ten, at most four
//   times). Digits then leave one word per registered digit store read
//   (S_RD, then S_OUT); Roman characters at one per cycle while the receiver
//   does not stall, with an extra step for each zero decimal place passed over.
// Reset and stall:
//   Reset restores radix 10, Roman mode off and clears the accumulator.
//   The result word sits in an output register; a stalled receiver holds the
//   sequencer, and the next symbol is taken once the final word is loaded.
module radix_and_roman_converter #(
  parameter int VALUE_WIDTH = rrc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rrc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rrc_in_if.sink                        in_if,
  rrc_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrc_pkg::RADIX_W-1:0]   cfg_data
);
  import rrc_pkg::*;

  localparam int PW   = VALUE_WIDTH + RADIX_W;
  localparam int AW   = $clog2(MAX_DIGITS);
  localparam int CNTW = $clog2(MAX_DIGITS + 1);
  localparam logic [63:0] LIM64 =
    ((VALUE_WIDTH >= 64) || (((64'd1 << VALUE_WIDTH) - 64'd1) >= DEC_LIMIT)) ?
    DEC_LIMIT : ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam logic [VALUE_WIDTH-1:0] ValueLimit = LIM64[VALUE_WIDTH-1:0];

  logic [RADIX_W-1:0] src_radix_r;
  logic [RADIX_W-1:0] tgt_radix_r;
  logic               roman_r;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] accum_r, accum_nxt;
  logic [ERR_W-1:0]       err_r, err_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [PLACE_W-1:0]     place_r, place_nxt;
  logic [SUB_W-1:0]       sub_r, sub_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [ERR_W-1:0]       out_err_r, out_err_nxt;

  logic [PW-1:0]          prod_r;
  logic [RADIX_W-1:0]     d_r;
  logic                   bad_r;
  logic                   last_r;
  logic [ROMAN_D_W-1:0]   rom_d_r [4];

  logic                   in_accept;
  logic [RADIX_W:0]       sym_dec;
  logic [PW-1:0]          sum;
  logic                   out_free;
  logic                   roman_bad;
  logic [RADIX_W-1:0]     div_radix;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]     div_rem;
  logic                   dst_we;
  logic [RADIX_W-1:0]     dst_rdata;
  logic [ROMAN_D_W-1:0]   eff_d [4];
  logic [ROMAN_D_W-1:0]   cur_d;
  logic [SUB_W-1:0]       cur_len;
  logic                   lower_zero;
  logic                   rom_last;

  rrc_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (accum_r),
    .divisor   (div_radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rrc_dstore #(.DEPTH(MAX_DIGITS)) u_dstore (
    .clk   (clk),
    .we    (dst_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rem),
    .raddr (idx_r),
    .rdata (dst_rdata)
  );

  assign in_accept = in_if.valid && in_if.ready;
  assign in_if.ready = rst_n && (state_r == S_IDLE);
  assign sym_dec   = decode_symbol(in_if.symbol);
  assign sum       = prod_r + PW'(d_r);
  assign out_free  = !out_valid_r || out_if.ready;
  assign roman_bad = (accum_r == '0) || (64'(accum_r) > ROMAN_MAX);
  assign div_radix = roman_r ? ROMAN_RADIX : tgt_radix_r;

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      eff_d[q] = (CNTW'(q) < cnt_r) ? rom_d_r[q] : '0;
    end
  end

  always_comb begin
    lower_zero = 1'b1;
    for (int q = 0; q < 3; q++) begin
      if (PLACE_W'(q) < place_r && eff_d[q] != '0) lower_zero = 1'b0;
    end
  end

  assign cur_d    = eff_d[place_r];
  assign cur_len  = roman_len(cur_d);
  assign rom_last = (sub_r == cur_len - 1'b1) && lower_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_radix_r <= RADIX_RESET;
      tgt_radix_r <= RADIX_RESET;
      roman_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_BASE: src_radix_r <= clamp_radix(cfg_data);
        REG_TARGET_BASE: tgt_radix_r <= clamp_radix(cfg_data);
        REG_ROMAN_MODE:  roman_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    accum_nxt     = accum_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    place_nxt     = place_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    div_start     = 1'b0;
    dst_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) state_nxt = S_ADD;
      end
      S_ADD: begin
        if (bad_r) begin
          err_nxt = ERR_SYMBOL;
        end else if (sum > PW'(ValueLimit)) begin
          accum_nxt = ValueLimit;
          if (err_r < ERR_OVERFLOW) err_nxt = ERR_OVERFLOW;
        end else begin
          accum_nxt = sum[VALUE_WIDTH-1:0];
        end
        state_nxt = last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (err_r == ERR_NONE && roman_r && roman_bad) begin
          err_nxt   = ERR_ROMAN;
          state_nxt = S_ERR;
        end else if (err_r != ERR_NONE) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_DIV_START;
        end
      end
      S_DIV_START: begin
        if (cnt_r >= CNTW'(MAX_DIGITS)) begin
          err_nxt   = ERR_OVERFLOW;
          state_nxt = S_ERR;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          dst_we    = !roman_r;
          cnt_nxt   = cnt_r + 1'b1;
          accum_nxt = div_quot;
          if (div_quot == '0) begin
            if (roman_r) begin
              place_nxt = '1;
              sub_nxt   = '0;
              state_nxt = S_ROMAN;
            end else begin
              idx_nxt   = cnt_r[AW-1:0];
              state_nxt = S_RD;
            end
          end else begin
            state_nxt = S_DIV_START;
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(dst_rdata);
          out_last_nxt  = (idx_r == '0);
          out_err_nxt   = ERR_NONE;
          if (idx_r == '0) begin
            accum_nxt = '0;
            err_nxt   = ERR_NONE;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_ROMAN: begin
        if (cur_len == '0) begin
          place_nxt = place_r - 1'b1;
          sub_nxt   = '0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = roman_char(place_r, cur_d, sub_r);
          out_last_nxt  = rom_last;
          out_err_nxt   = ERR_NONE;
          if (rom_last) begin
            accum_nxt = '0;
            err_nxt   = ERR_NONE;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else if (sub_r == cur_len - 1'b1) begin
            sub_nxt   = '0;
            place_nxt = place_r - 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_NUL;
          out_last_nxt  = 1'b1;
          out_err_nxt   = err_r;
          accum_nxt     = '0;
          err_nxt       = ERR_NONE;
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      accum_r     <= '0;
      err_r       <= ERR_NONE;
      cnt_r       <= '0;
      idx_r       <= '0;
      place_r     <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      place_r     <= place_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    if (in_accept) begin
      prod_r <= PW'(accum_r) * PW'(src_radix_r);
      d_r    <= sym_dec[RADIX_W-1:0];
      bad_r  <= sym_dec >= {1'b0, src_radix_r};
      last_r <= in_if.last_symbol;
    end
    if (state_r == S_DIV_WAIT && div_done && roman_r) begin
      rom_d_r[cnt_r[1:0]] <= div_rem[ROMAN_D_W-1:0];
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_char   = out_char_r;
  assign out_if.last_char  = out_last_r;
  assign out_if.error_code = out_err_r;

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.error_code != ERR_NONE |->
      out_if.last_char && out_if.out_char == CHAR_NUL)
    else $error("error word is not a lone null word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_accum_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> accum_r <= ValueLimit)
    else $error("accumulator above value limit");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=>
      out_if.valid && $stable(out_if.out_char) && $stable(out_if.error_code))
    else $error("stalled result word changed");

endmodule

### dv/tb_radix_and_roman_converter.sv
// Self-checking testbench for radix_and_roman_converter: digit symbols go in on
// in_if, every result word on out_if is compared with a local predictor.
// Depends on rrc_pkg, rrc_in_if, rrc_out_if and the converter RTL.
module tb_radix_and_roman_converter;
  import rrc_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 600;
  localparam int PRINT_CAP    = 40;

  localparam logic [63:0] WIDTH_CAP = (VALUE_WIDTH_DEF >= 64) ? '1 :
                                      ((64'd1 << VALUE_WIDTH_DEF) - 64'd1);
  localparam logic [63:0] ACC_LIMIT = (WIDTH_CAP < DEC_LIMIT) ? WIDTH_CAP : DEC_LIMIT;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic             is_last;
    logic [ERR_W-1:0] code;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADIX_W-1:0]   cfg_data;
  logic                 rx_hold;

  rrc_in_if  in_ch ();
  rrc_out_if out_ch ();

  radix_and_roman_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  sym_word_t  symbol_backlog[$];
  char_word_t pending_chars[$];
  sym_word_t  drv_word;

  int symbols_queued = 0;
  int symbols_taken  = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  logic [RADIX_W-1:0] src_radix_reg;
  logic [RADIX_W-1:0] tgt_radix_reg;
  logic               roman_on;
  logic [63:0]        acc_value;
  logic [ERR_W-1:0]   num_error;

  function automatic int unsigned bounded_radix(logic [RADIX_W-1:0] r);
    if (r < 2) return 2;
    if (r > 36) return 36;
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] sym_for(int unsigned d);
    if (d < 10) return CHAR_0 + SYM_W'(d);
    return CHAR_A + SYM_W'(d - 10);
  endfunction

  function automatic void raise_error(logic [ERR_W-1:0] code);
    if (code > num_error) num_error = code;
  endfunction

  function automatic void add_expected(char_word_t w);
    pending_chars.insert(pending_chars.size(), w);
  endfunction

  function automatic void push_char(logic [SYM_W-1:0] c);
    add_expected('{ch: c, is_last: 1'b0, code: ERR_NONE});
  endfunction

  function automatic void add_roman_place(int d, logic [SYM_W-1:0] one,
                                          logic [SYM_W-1:0] five, logic [SYM_W-1:0] ten);
    if (d == 9) begin
      push_char(one);
      push_char(ten);
    end else if (d == 4) begin
      push_char(one);
      push_char(five);
    end else begin
      if (d >= 5) begin
        push_char(five);
        d -= 5;
      end
      repeat (d) push_char(one);
    end
  endfunction

  function automatic void emit_number();
    logic [RADIX_W-1:0] digs[64];
    logic [63:0]        v;
    logic [63:0]        r;
    int                 n;
    int                 rv;
    char_word_t         tail;
    v = acc_value;
    n = 0;
    if (num_error == ERR_NONE && roman_on && (v == 0 || v > ROMAN_MAX)) raise_error(ERR_ROMAN);
    if (num_error == ERR_NONE && !roman_on) begin
      r = bounded_radix(tgt_radix_reg);
      do begin
        if (n >= MAX_DIGITS_DEF) begin
          raise_error(ERR_OVERFLOW);
          break;
        end
        digs[n] = RADIX_W'(v % r);
        n++;
        v = v / r;
      end while (v != 0);
    end
    if (num_error != ERR_NONE) begin
      add_expected('{ch: CHAR_NUL, is_last: 1'b1, code: num_error});
      return;
    end
    if (roman_on) begin
      rv = int'(v);
      repeat (rv / 1000) push_char("M");
      add_roman_place((rv / 100) % 10, "C", "D", "M");
      add_roman_place((rv / 10) % 10, "X", "L", "C");
      add_roman_place(rv % 10, "I", "V", "X");
    end else begin
      for (int i = n - 1; i >= 0; i--) push_char(sym_for(digs[i]));
    end
    tail = pending_chars.pop_back();
    tail.is_last = 1'b1;
    add_expected(tail);
  endfunction

  function automatic void fold_symbol(logic [SYM_W-1:0] sym, logic last);
    int unsigned digit;
    logic [63:0] r;
    logic [63:0] nv;
    digit = 64;
    r = bounded_radix(src_radix_reg);
    if (sym >= CHAR_0 && sym <= CHAR_9) digit = sym - CHAR_0;
    else if (sym >= CHAR_A && sym <= CHAR_Z) digit = sym - CHAR_A + 10;
    if (digit >= r) begin
      raise_error(ERR_SYMBOL);
    end else begin
      nv = acc_value * r + 64'(digit);
      if (nv > ACC_LIMIT) begin
        nv = ACC_LIMIT;
        raise_error(ERR_OVERFLOW);
      end
      acc_value = nv;
    end
    if (last) begin
      emit_number();
      acc_value = '0;
      num_error = ERR_NONE;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_char(logic [SYM_W-1:0] ch, logic is_last, logic [ERR_W-1:0] code);
    char_word_t exp_word;
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("word with nothing pending: char %02h last %0b code %0d",
                                ch, is_last, code));
      return;
    end
    exp_word = pending_chars.pop_front();
    if (ch !== exp_word.ch)
      report_mismatch($sformatf("out_char %02h, want %02h", ch, exp_word.ch));
    if (is_last !== exp_word.is_last)
      report_mismatch($sformatf("last_char %0b, want %0b", is_last, exp_word.is_last));
    if (code !== exp_word.code)
      report_mismatch($sformatf("error_code %0d, want %0d", code, exp_word.code));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_radix_and_roman_converter: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fold_symbol(in_ch.symbol, in_ch.last_symbol);
        symbols_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (symbol_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word = symbol_backlog.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.symbol      <= drv_word.symbol;
          in_ch.last_symbol <= drv_word.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_char(out_ch.out_char, out_ch.last_char, out_ch.error_code);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_word(logic [SYM_W-1:0] s, logic last);
    sym_word_t w;
    w = '{symbol: s, last: last};
    symbol_backlog.insert(symbol_backlog.size(), w);
    symbols_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIX_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SOURCE_BASE: src_radix_reg = val;
      REG_TARGET_BASE: tgt_radix_reg = val;
      REG_ROMAN_MODE:  roman_on = val[0];
      default: ;
    endcase
  endtask

  task automatic begin_phase(logic [RADIX_W-1:0] sb, logic [RADIX_W-1:0] tb,
                             logic [RADIX_W-1:0] rm, int idle, int stall);
    write_reg(REG_SOURCE_BASE, sb);
    write_reg(REG_TARGET_BASE, tb);
    write_reg(REG_ROMAN_MODE, rm);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
  endtask

  task automatic wait_quiet();
    while (symbols_taken != symbols_queued || pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_number();
    int unsigned r;
    int          kind;
    int          len;
    int          over_len;
    int          roman_cap;
    int          bad_pos;
    int unsigned d;
    logic [63:0] p;
    bit          overflow;
    r = bounded_radix(src_radix_reg);
    kind = $urandom_range(99);
    overflow = 1'b0;
    p = 1;
    over_len = 1;
    while (p <= ACC_LIMIT) begin
      p = p * r;
      over_len++;
    end
    p = 1;
    roman_cap = 0;
    while (p <= ROMAN_MAX) begin
      p = p * r;
      roman_cap++;
    end
    if (kind < 12 && r >= 8) begin
      overflow = 1'b1;
      len = over_len + $urandom_range(0, 1);
    end else if (roman_on) begin
      len = $urandom_range(1, roman_cap);
    end else if (kind < 30) begin
      len = $urandom_range(7, 13);
    end else begin
      len = $urandom_range(1, 5);
    end
    bad_pos = (kind >= 85) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      d = $urandom_range(0, r - 1);
      if (i == 0 && overflow && d == 0) d = 1;
      if (i == bad_pos) queue_word(SYM_W'($urandom_range(0, 255)), i == len - 1);
      else queue_word(sym_for(d), i == len - 1);
    end
  endtask

  task automatic run_random_phase(logic [RADIX_W-1:0] sb, logic [RADIX_W-1:0] tb,
                                  logic [RADIX_W-1:0] rm, int idle, int stall,
                                  int items, bit hold);
    int start;
    begin_phase(sb, tb, rm, idle, stall);
    start = symbols_queued;
    if (hold) begin
      fork
        begin
          rx_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          rx_hold <= 1'b0;
        end
      join_none
    end
    while (symbols_queued - start < items) queue_random_number();
    wait_quiet();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SOURCE_BASE;
    cfg_data          = '0;
    rx_hold           = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.symbol      = '0;
    in_ch.last_symbol = 1'b0;
    out_ch.ready      = 1'b0;
    src_radix_reg     = RADIX_RESET;
    tgt_radix_reg     = RADIX_RESET;
    roman_on          = 1'b0;
    acc_value         = '0;
    num_error         = ERR_NONE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // edge symbols and plain decimal
    begin_phase(6'd10, 6'd10, 6'd0, 0, 0);
    queue_word("0", 1'b1);
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b1);
    queue_word("/", 1'b1);
    queue_word("A", 1'b1);
    queue_word("9", 1'b0);
    queue_word("9", 1'b1);
    wait_quiet();

    // saturate the accumulator
    begin_phase(6'd36, 6'd2, 6'd0, 0, 0);
    for (int i = 0; i < 10; i++) queue_word("Z", i == 9);
    wait_quiet();

    // Roman range limits, bad symbol over Roman range, subtractive forms
    begin_phase(6'd10, 6'd10, 6'd1, 0, 0);
    queue_word("0", 1'b1);
    queue_word("@", 1'b0);
    queue_word("0", 1'b1);
    queue_word("3", 1'b0);
    queue_word("0", 1'b0);
    queue_word("0", 1'b0);
    queue_word("1", 1'b1);
    queue_word("2", 1'b0);
    queue_word("9", 1'b0);
    queue_word("4", 1'b0);
    queue_word("9", 1'b1);
    wait_quiet();

    run_random_phase(6'd16, 6'd36, 6'd0,  0,  0, 32, 1'b0);
    run_random_phase(6'd2,  6'd10, 6'd0, 71,  0, 32, 1'b0);
    run_random_phase(6'd36, 6'd2,  6'd0,  0, 71, 28, 1'b0);
    run_random_phase(6'd10, 6'd16, 6'd1,  6,  6, 32, 1'b0);
    run_random_phase(6'd0,  6'd63, 6'd0, 71, 71, 28, 1'b0);
    run_random_phase(6'd10, 6'd2,  6'd0,  0,  0, 36, 1'b1);
    run_random_phase(6'd16, 6'd10, 6'd3,  0, 71, 28, 1'b0);
    run_random_phase(6'd1,  6'd37, 6'd0,  6,  6, 34, 1'b0);

    if (error_count == 0) begin
      $display("tb_radix_and_roman_converter: clean");
    end else begin
      $display("tb_radix_and_roman_converter: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/rrc_pkg.sv
rtl/rrc_in_if.sv
rtl/rrc_out_if.sv
rtl/rrc_div.sv
rtl/rrc_dstore.sv
rtl/radix_and_roman_converter.sv
dv/tb_radix_and_roman_converter.sv
